### rtl/core/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// Request and result payload structs, field widths, codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package dsu_pkg;

    // Field widths fixed by the interface
    localparam int NODE_W = 10;
    localparam int RANK_W = 4;
    localparam int SIZE_W = 11;

    // Default forest size
    localparam int NODES_DEF = 1024;

    // Saturation limits of the per-root counters
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;

    // Request codes
    localparam logic REQ_UNION = 1'b0;
    localparam logic REQ_FIND  = 1'b1;

    // Link policy codes
    localparam logic MODE_RANK = 1'b0;
    localparam logic MODE_SIZE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } dsu_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] root_index;
        logic              merged;
        logic [SIZE_W-1:0] set_size;
    } dsu_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_LINK,
        ST_LINK2,
        ST_FIN
    } dsu_state_t;

endpackage

### rtl/core/dsu_store.sv
// Node store of the disjoint-set union engine: one write port, one registered read port.
// Each word packs parent pointer, rank and set size. Depends on nothing.
`timescale 1ns / 1ps

module dsu_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 25
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/disjoint_set_union_engine_top.sv
// Top level of the disjoint-set union engine: request sequencer, link logic, result register.
// Depends on dsu_pkg and dsu_store.
`timescale 1ns / 1ps

// Union-find over NODES elements with path compression. After reset the block runs a
// clearing pass through the node store (each element its own root, rank 0, size 1)
// and takes no request until it ends; link-mode writes are taken at any time.
// One request is in work at a time. All work goes through the node store, one read and one
// write a cycle: a walk follows the chain to its root, then compression points each node
// on the path at that root. Out-of-range indexes are clamped to NODES-1. A finished
// result waits in the output register; the next request is accepted while it waits.

module disjoint_set_union_engine_top #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dsu_pkg::dsu_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dsu_pkg::dsu_rsp_t rsp_data,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data
);

    import dsu_pkg::*;

    localparam int IDX_W   = $clog2(NODES);
    localparam int EXT_W   = (IDX_W > NODE_W) ? IDX_W : NODE_W;
    localparam int ENTRY_W = IDX_W + RANK_W + SIZE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    typedef struct packed {
        logic [IDX_W-1:0]  parent;
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // Clamp a request index into the store
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [NODE_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext >= EXT_W'(NODES - 1))
        begin
            return LAST_IDX;
        end
        return IDX_W'(ext);
    endfunction

    dsu_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              mode_reg;
    logic              req_type_reg, req_type_next;
    logic              second_reg, second_next;
    logic [IDX_W-1:0]  b_idx_reg, b_idx_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [SIZE_W-1:0] size_a_reg, size_a_next;
    logic [IDX_W-1:0]  rb_reg, rb_next;
    logic [RANK_W-1:0] rank_b_reg, rank_b_next;
    logic [SIZE_W-1:0] size_b_reg, size_b_next;
    logic [IDX_W-1:0]  surv_reg, surv_next;
    logic [RANK_W-1:0] surv_rank_reg, surv_rank_next;
    logic [SIZE_W-1:0] surv_size_reg, surv_size_next;
    logic              merged_reg, merged_next;
    logic              rsp_valid_reg, rsp_valid_next;
    dsu_rsp_t          rsp_data_reg, rsp_data_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t            rd_entry;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_entry;

    logic [IDX_W-1:0]  root_cur;
    logic              find_done;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W-1:0] size_sat;
    logic [RANK_W-1:0] rank_inc;

    // Node store
    dsu_store #(
        .DEPTH  (NODES),
        .DATA_W (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    assign rd_entry = rd_data;

    // Root of the chain now being compressed
    assign root_cur = second_reg ? rb_reg : ra_reg;

    // Saturating size sum and rank increment for the link step
    assign size_sum = {1'b0, size_a_reg} + {1'b0, size_b_reg};
    assign size_sat = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
    assign rank_inc = (rank_a_reg == RANK_MAX) ? rank_a_reg : rank_a_reg + RANK_W'(1);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= MODE_RANK;
            second_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            second_reg    <= second_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Hold request payload and walk registers
    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        b_idx_reg     <= b_idx_next;
        start_reg     <= start_next;
        cur_reg       <= cur_next;
        ra_reg        <= ra_next;
        rank_a_reg    <= rank_a_next;
        size_a_reg    <= size_a_next;
        rb_reg        <= rb_next;
        rank_b_reg    <= rank_b_next;
        size_b_reg    <= size_b_next;
        surv_reg      <= surv_next;
        surv_rank_reg <= surv_rank_next;
        surv_size_reg <= surv_size_next;
        merged_reg    <= merged_next;
        rsp_data_reg  <= rsp_data_next;
    end

    // Sequence the walk, compression, link and result
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        req_type_next  = req_type_reg;
        second_next    = second_reg;
        b_idx_next     = b_idx_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        rank_a_next    = rank_a_reg;
        size_a_next    = size_a_reg;
        rb_next        = rb_reg;
        rank_b_next    = rank_b_reg;
        size_b_next    = size_b_reg;
        surv_next      = surv_reg;
        surv_rank_next = surv_rank_reg;
        surv_size_next = surv_size_reg;
        merged_next    = merged_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_entry       = '0;
        find_done      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the store back to singleton sets
                wr_en    = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_entry = '{parent: clr_cnt_reg, rank: '0, size: SIZE_W'(1)};
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                // Take a request and fetch its first node
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_type_next = req_data.req_type;
                    start_next    = clamp_idx(req_data.node_a);
                    cur_next      = clamp_idx(req_data.node_a);
                    b_idx_next    = clamp_idx(req_data.node_b);
                    second_next   = 1'b0;
                    rd_en         = 1'b1;
                    rd_addr       = clamp_idx(req_data.node_a);
                    state_next    = ST_WALK;
                end
            end

            ST_WALK:
            begin
                // Follow one parent link per cycle until a self-pointer
                if (rd_entry.parent == cur_reg)
                begin
                    if (second_reg)
                    begin
                        rb_next     = cur_reg;
                        rank_b_next = rd_entry.rank;
                        size_b_next = rd_entry.size;
                    end
                    else
                    begin
                        ra_next     = cur_reg;
                        rank_a_next = rd_entry.rank;
                        size_a_next = rd_entry.size;
                    end
                    if (cur_reg == start_reg)
                    begin
                        find_done = 1'b1;
                    end
                    else
                    begin
                        cur_next   = start_reg;
                        rd_en      = 1'b1;
                        rd_addr    = start_reg;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    cur_next = rd_entry.parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_entry.parent;
                end
            end

            ST_COMP:
            begin
                // Point this node at the root and fetch the next one on the path
                wr_en    = 1'b1;
                wr_addr  = cur_reg;
                wr_entry = '{parent: root_cur, rank: rd_entry.rank, size: rd_entry.size};
                if (rd_entry.parent == root_cur)
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    cur_next = rd_entry.parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_entry.parent;
                end
            end

            ST_LINK:
            begin
                // Pick the survivor and, for a union of two distinct roots, hang the other root under it
                surv_next      = ra_reg;
                surv_rank_next = rank_a_reg;
                surv_size_next = size_a_reg;
                merged_next    = 1'b0;
                state_next     = ST_FIN;
                if (req_type_reg == REQ_UNION && ra_reg != rb_reg)
                begin
                    merged_next = 1'b1;
                    wr_en       = 1'b1;
                    state_next  = ST_LINK2;
                    if (mode_reg == MODE_RANK)
                    begin
                        if (rank_a_reg < rank_b_reg)
                        begin
                            surv_next      = rb_reg;
                            surv_rank_next = rank_b_reg;
                            surv_size_next = size_b_reg;
                            wr_addr        = ra_reg;
                            wr_entry       = '{parent: rb_reg, rank: rank_a_reg,
                                               size: size_a_reg};
                        end
                        else
                        begin
                            if (rank_a_reg == rank_b_reg)
                            begin
                                surv_rank_next = rank_inc;
                            end
                            wr_addr  = rb_reg;
                            wr_entry = '{parent: ra_reg, rank: rank_b_reg, size: size_b_reg};
                        end
                    end
                    else
                    begin
                        surv_size_next = size_sat;
                        if (size_a_reg < size_b_reg)
                        begin
                            surv_next      = rb_reg;
                            surv_rank_next = rank_b_reg;
                            wr_addr        = ra_reg;
                            wr_entry       = '{parent: rb_reg, rank: rank_a_reg,
                                               size: size_a_reg};
                        end
                        else
                        begin
                            wr_addr  = rb_reg;
                            wr_entry = '{parent: ra_reg, rank: rank_b_reg, size: size_b_reg};
                        end
                    end
                end
            end

            ST_LINK2:
            begin
                // Store the survivor's updated rank and size
                wr_en      = 1'b1;
                wr_addr    = surv_reg;
                wr_entry   = '{parent: surv_reg, rank: surv_rank_reg, size: surv_size_reg};
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                // Load the result once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_data_next.root_index = NODE_W'(EXT_W'(surv_reg));
                    rsp_data_next.merged     = merged_reg;
                    rsp_data_next.set_size   = surv_size_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Start the second find of a union, or move on to the link step
        if (find_done)
        begin
            if (!second_reg && req_type_reg == REQ_UNION)
            begin
                second_next = 1'b1;
                start_next  = b_idx_reg;
                cur_next    = b_idx_reg;
                rd_en       = 1'b1;
                rd_addr     = b_idx_reg;
                state_next  = ST_WALK;
            end
            else
            begin
                state_next = ST_LINK;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef ASSERT_OFF
    a_no_req_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_ready)
        else $error("request taken during clearing pass");

    a_one_req_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while one is in work");

    a_comp_skips_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (wr_addr != root_cur))
        else $error("compression rewrote the root entry");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the result step");

    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK2) |-> (ra_reg != rb_reg && req_type_reg == REQ_UNION))
        else $error("survivor update without two distinct roots");
`endif

endmodule

### verif/tb_disjoint_set_union_engine_top.sv
// Self-checking testbench for the disjoint-set union engine: directed and pooled random
// finds and unions in both link modes, checked against a forest kept in step beside it.
// Depends on dsu_pkg and disjoint_set_union_engine_top.
`timescale 1ns / 1ps

// Shadow forest: predicts each result and holds the results still owed by the block
class dsu_scoreboard;
    logic [dsu_pkg::NODE_W-1:0] parent_of [dsu_pkg::NODES_DEF];
    logic [dsu_pkg::RANK_W-1:0] rank_of   [dsu_pkg::NODES_DEF];
    logic [dsu_pkg::SIZE_W-1:0] size_of   [dsu_pkg::NODES_DEF];
    logic                       link_mode;
    dsu_pkg::dsu_rsp_t          expected_q [$];
    int                         mismatches;
    int                         results_seen;
    int                         finds;
    int                         unions;
    int                         rank_links;
    int                         size_links;

    function new();
        for (int i = 0; i < dsu_pkg::NODES_DEF; i++)
        begin
            parent_of[i] = dsu_pkg::NODE_W'(i);
            rank_of[i]   = '0;
            size_of[i]   = dsu_pkg::SIZE_W'(1);
        end
        link_mode    = dsu_pkg::MODE_RANK;
        mismatches   = 0;
        results_seen = 0;
        finds        = 0;
        unions       = 0;
        rank_links   = 0;
        size_links   = 0;
    endfunction

    // Walk to the root, then point every node on the path straight at it
    function logic [dsu_pkg::NODE_W-1:0] root_of(logic [dsu_pkg::NODE_W-1:0] start);
        logic [dsu_pkg::NODE_W-1:0] root;
        logic [dsu_pkg::NODE_W-1:0] cur;
        logic [dsu_pkg::NODE_W-1:0] nxt;
        int                         steps;
        root  = start;
        steps = 0;
        while (parent_of[root] != root && steps < dsu_pkg::NODES_DEF)
        begin
            root = parent_of[root];
            steps++;
        end
        cur   = start;
        steps = 0;
        while (cur != root && steps < dsu_pkg::NODES_DEF)
        begin
            nxt            = parent_of[cur];
            parent_of[cur] = root;
            cur            = nxt;
            steps++;
        end
        return root;
    endfunction

    // Apply one accepted request to the shadow forest and queue its result
    function void note_request(dsu_pkg::dsu_req_t r);
        logic [dsu_pkg::NODE_W-1:0] ra;
        logic [dsu_pkg::NODE_W-1:0] rb;
        logic [dsu_pkg::NODE_W-1:0] survivor;
        logic [dsu_pkg::SIZE_W:0]   sum;
        dsu_pkg::dsu_rsp_t          want;
        ra          = root_of(r.node_a);
        survivor    = ra;
        want.merged = 1'b0;
        if (r.req_type == dsu_pkg::REQ_UNION)
        begin
            unions++;
            rb = root_of(r.node_b);
            if (ra != rb)
            begin
                want.merged = 1'b1;
                if (link_mode == dsu_pkg::MODE_RANK)
                begin
                    rank_links++;
                    if (rank_of[ra] < rank_of[rb])
                    begin
                        parent_of[ra] = rb;
                        survivor      = rb;
                    end
                    else if (rank_of[rb] < rank_of[ra])
                    begin
                        parent_of[rb] = ra;
                    end
                    else
                    begin
                        // Tie: b's root goes under a's, whose rank grows unless saturated
                        parent_of[rb] = ra;
                        if (rank_of[ra] != dsu_pkg::RANK_MAX)
                            rank_of[ra] = rank_of[ra] + 1'b1;
                    end
                end
                else
                begin
                    size_links++;
                    sum = size_of[ra] + size_of[rb];
                    if (sum > dsu_pkg::SIZE_MAX)
                        sum = dsu_pkg::SIZE_MAX;
                    if (size_of[ra] < size_of[rb])
                    begin
                        parent_of[ra] = rb;
                        size_of[rb]   = sum[dsu_pkg::SIZE_W-1:0];
                        survivor      = rb;
                    end
                    else
                    begin
                        parent_of[rb] = ra;
                        size_of[ra]   = sum[dsu_pkg::SIZE_W-1:0];
                    end
                end
            end
        end
        else
        begin
            finds++;
        end
        want.root_index = survivor;
        want.set_size   = size_of[survivor];
        expected_q.push_back(want);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(dsu_pkg::dsu_rsp_t got);
        dsu_pkg::dsu_rsp_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: root %0d merged %0d size %0d",
                         got.root_index, got.merged, got.set_size);
            return;
        end
        want = expected_q.pop_front();
        if (got.root_index !== want.root_index || got.merged !== want.merged ||
            got.set_size !== want.set_size)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d mismatch: root %0d/%0d merged %0d/%0d size %0d/%0d %s",
                         results_seen, want.root_index, got.root_index, want.merged,
                         got.merged, want.set_size, got.set_size, "(expected/actual)");
        end
    endfunction
endclass

module tb_disjoint_set_union_engine_top;
    import dsu_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SEGMENT_ITEMS = 75;
    localparam int SEGMENTS      = 6;
    localparam int IDLE_SETTLE   = 6;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     req_valid   = 1'b0;
    logic     req_ready;
    dsu_req_t req_data    = '0;
    logic     rsp_valid;
    logic     rsp_ready   = 1'b0;
    dsu_rsp_t rsp_data;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycle_count   = 0;
    dsu_scoreboard sb;

    disjoint_set_union_engine_top #(
        .NODES(NODES_DEF)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
    begin
        rsp_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog, then note accepted requests and check accepted results
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("tb_disjoint_set_union_engine_top: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp_data);
            if (req_valid && req_ready)
                sb.note_request(req_data);
        end
    end

    // Present one request, with random idle cycles ahead of it, and hold it until taken
    task automatic drive_request(input dsu_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid         = 1'b0;
            req_data.req_type = 1'($urandom);
            req_data.node_a   = NODE_W'($urandom);
            req_data.node_b   = NODE_W'($urandom);
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = r;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic send_op(input logic kind, input int a, input int b);
        dsu_req_t r;
        r.req_type = kind;
        r.node_a   = NODE_W'(a);
        r.node_b   = NODE_W'(b);
        drive_request(r);
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        req_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic write_link_mode(input logic mode);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        sb.link_mode = mode;
    endtask

    // Mostly requests within a small pool so trees grow deep, some across the whole range
    function automatic dsu_req_t pick_request(int pool_base, int pool_span);
        dsu_req_t r;
        if ($urandom_range(99) < 85)
        begin
            r.req_type = ($urandom_range(99) < 45) ? REQ_FIND : REQ_UNION;
            r.node_a   = NODE_W'(pool_base + $urandom_range(pool_span - 1));
            r.node_b   = NODE_W'(pool_base + $urandom_range(pool_span - 1));
        end
        else
        begin
            r.req_type = 1'($urandom);
            r.node_a   = NODE_W'($urandom);
            r.node_b   = NODE_W'($urandom);
        end
        return r;
    endfunction

    initial
    begin
        int pool_base;
        int pool_span;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Link by rank: fresh finds, ties, higher rank on either side, same-set unions
        write_link_mode(MODE_RANK);
        send_op(REQ_FIND,  0,    1023);
        send_op(REQ_FIND,  1023, 0);
        send_op(REQ_UNION, 0,    1023);
        send_op(REQ_UNION, 512,  0);
        send_op(REQ_UNION, 0,    341);
        send_op(REQ_UNION, 1023, 512);
        send_op(REQ_UNION, 7,    7);
        send_op(REQ_UNION, 682,  681);
        send_op(REQ_UNION, 681,  1023);
        send_op(REQ_FIND,  1023, 682);
        send_op(REQ_FIND,  511,  1023);
        wait_drained();

        // Link by size: equal sizes, smaller side first, stale sizes left by rank links
        write_link_mode(MODE_SIZE);
        send_op(REQ_UNION, 100,  101);
        send_op(REQ_UNION, 102,  100);
        send_op(REQ_UNION, 100,  200);
        send_op(REQ_UNION, 0,    100);
        send_op(REQ_FIND,  1023, 0);
        send_op(REQ_UNION, 300,  300);
        send_op(REQ_FIND,  102,  1023);
        send_op(REQ_UNION, 1000, 24);
        send_op(REQ_UNION, 24,   1023);
        wait_drained();

        // Random segments: sender mostly busy, then receiver mostly busy, then no idling
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:       begin send_idle_pct = 23; recv_idle_pct = 70; end
                1:       begin send_idle_pct = 70; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            write_link_mode((seg % 2 == 0) ? MODE_SIZE : MODE_RANK);
            pool_span = 16 << $urandom_range(2);
            pool_base = $urandom_range(NODES_DEF - pool_span);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                // Hold the sender mid-segment until the block has emptied
                if ((seg == 1 || seg == 4) && n == SEGMENT_ITEMS / 2)
                    wait_drained();
                drive_request(pick_request(pool_base, pool_span));
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        $display("ran %0d finds and %0d unions; %0d sets linked by rank, %0d by size",
                 sb.finds, sb.unions, sb.rank_links, sb.size_links);
        $display("%0d results compared, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb_disjoint_set_union_engine_top: clean");
        else
            $display("tb_disjoint_set_union_engine_top: errors");
        $finish;
    end
endmodule
